// File: src/spb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_pkg
// Shared sizes, event and command codes, and the staged result record for
// the SPI packet bridge slave core.
// ----------------------------------------------------------------------------
package spb_pkg;

	localparam int RX_DEPTH      = 8;
	localparam int TX_DEPTH      = 8;
	localparam int PAYLOAD_BYTES = 12;

	localparam int ARG_BYTES = 12;
	localparam int ARG_W     = ARG_BYTES * 8;
	localparam int PKT_W     = PAYLOAD_BYTES * 8;
	localparam int WORD_BYTES = 4;

	localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int RX_LW = $clog2(RX_DEPTH + 1);
	localparam int TX_LW = $clog2(TX_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_SPI_END    = 2'd0,
		ACT_RADIO_RX   = 2'd1,
		ACT_RADIO_SLOT = 2'd2,
		ACT_IGNORED    = 2'd3
	} action_t;

	localparam logic [7:0] CMD_NONE      = 8'd0;
	localparam logic [7:0] CMD_READ_BUF  = 8'd1;
	localparam logic [7:0] CMD_WRITE_BUF = 8'd2;
	localparam logic [7:0] CMD_READ_REG  = 8'd3;
	localparam logic [7:0] CMD_WRITE_REG = 8'd4;

	localparam logic [7:0] REG_RX_COUNT  = 8'd2;
	localparam logic [7:0] REG_TX_COUNT  = 8'd3;
	localparam logic [7:0] REG_OVERFLOW  = 8'd4;
	localparam logic [7:0] REG_MAC_SETUP = 8'd5;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_RX   = 2'd1,
		SRC_TX   = 2'd2,
		SRC_WORD = 2'd3
	} src_t;

	typedef struct packed {
		logic        resp_valid;
		logic [3:0]  data_len;
		src_t        src;
		logic [31:0] word;
		logic        ok;
		logic        irq_pulse;
		logic        send_request;
		logic        mac_config_valid;
		logic [7:0]  station_id;
		logic [7:0]  station_count;
	} result_t;

endpackage

// File: src/spb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module spb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/spi_packet_bridge_slave_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_packet_bridge_slave_core
// SPI-slave bridge between a host and a radio MAC with receive and transmit
// packet queues and a lost-packet counter.
// ----------------------------------------------------------------------------
// Each input beat is one event (SPI frame done, radio packet in, radio
// transmit slot) and yields exactly one result beat. in_stall is high while
// stage 1 is full. At the accepting edge the event is decoded, queue
// pointers move and the packet store read is registered; the result then
// moves into the output register once it is free. The next event is
// accepted while a finished result still waits on out_stall; a second
// result behind it holds in_stall high until the output register frees
// up. Both queues live in small synchronous RAMs; a config register write
// empties them by resetting pointers only, so there is no clearing pass.
// ----------------------------------------------------------------------------
module spi_packet_bridge_slave_core
	import spb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,

	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   action,
	input  logic [7:0]   command,
	input  logic [4:0]   frame_len,
	input  logic [63:0]  frame_low,
	input  logic [31:0]  frame_high,

	output logic         out_valid,
	input  logic         out_stall,
	output logic         resp_valid,
	output logic [3:0]   data_len,
	output logic [63:0]  data_low,
	output logic [31:0]  data_high,
	output logic         ok,
	output logic         irq_pulse,
	output logic         send_request,
	output logic         mac_config_valid,
	output logic [7:0]   station_id,
	output logic [7:0]   station_count
);

	logic [RX_AW-1:0] rx_head_q;
	logic [RX_LW-1:0] rx_level_q;
	logic [TX_AW-1:0] tx_head_q;
	logic [TX_LW-1:0] tx_level_q;
	logic [31:0]      overflow_q;

	logic             valid_s1;
	result_t          res_s1;
	logic             out_valid_q;
	result_t          res_q;
	logic [ARG_W-1:0] data_q;

	logic             accept;
	logic             load_out;
	logic [ARG_W-1:0] arg_raw;
	logic [ARG_W-1:0] arg_m;
	logic [PKT_W-1:0] fill;
	logic [7:0]       reg_sel;
	logic             rx_full, rx_empty, tx_full, tx_empty;
	logic             rx_push, rx_pop, tx_push, tx_pop;
	logic             ovf_inc, ovf_clr, q_clear;
	result_t          res_d;
	logic [ARG_W-1:0] data_d;

	logic [RX_LW:0]   rx_sum;
	logic [TX_LW:0]   tx_sum;
	logic [RX_AW-1:0] rx_waddr;
	logic [TX_AW-1:0] tx_waddr;
	logic [PKT_W-1:0] rx_rdata, tx_rdata;

	// argument bytes at or past frame_len read as zero
	assign arg_raw = {frame_high, frame_low};
	always_comb begin
		for (int i = 0; i < ARG_BYTES; i++) begin
			arg_m[i*8 +: 8] = (5'(i) < frame_len) ? arg_raw[i*8 +: 8] : 8'd0;
		end
	end
	assign fill    = arg_m[PKT_W-1:0];
	assign reg_sel = arg_m[7:0];

	assign in_stall = valid_s1;
	assign accept   = in_valid && !valid_s1;
	assign load_out = valid_s1 && (!out_valid_q || !out_stall);

	assign rx_full  = (rx_level_q == RX_LW'(RX_DEPTH));
	assign rx_empty = (rx_level_q == '0);
	assign tx_full  = (tx_level_q == TX_LW'(TX_DEPTH));
	assign tx_empty = (tx_level_q == '0);

	// tail = (head + level) mod depth; sum stays below twice the depth
	assign rx_sum = (RX_LW+1)'(rx_head_q) + (RX_LW+1)'(rx_level_q);
	assign tx_sum = (TX_LW+1)'(tx_head_q) + (TX_LW+1)'(tx_level_q);
	always_comb begin
		if (rx_sum >= (RX_LW+1)'(RX_DEPTH)) begin
			rx_waddr = RX_AW'(rx_sum - (RX_LW+1)'(RX_DEPTH));
		end else begin
			rx_waddr = RX_AW'(rx_sum);
		end
		if (tx_sum >= (TX_LW+1)'(TX_DEPTH)) begin
			tx_waddr = TX_AW'(tx_sum - (TX_LW+1)'(TX_DEPTH));
		end else begin
			tx_waddr = TX_AW'(tx_sum);
		end
	end

	// event decode
	always_comb begin
		res_d   = '0;
		rx_push = 1'b0;
		rx_pop  = 1'b0;
		tx_push = 1'b0;
		tx_pop  = 1'b0;
		ovf_inc = 1'b0;
		ovf_clr = 1'b0;
		q_clear = 1'b0;
		case (action_t'(action))
			ACT_RADIO_RX: begin
				if (!rx_full) begin
					rx_push       = 1'b1;
					res_d.ok        = 1'b1;
					res_d.irq_pulse = 1'b1;
				end else begin
					ovf_inc = 1'b1;
				end
			end
			ACT_RADIO_SLOT: begin
				if (!tx_empty) begin
					tx_pop         = 1'b1;
					res_d.ok       = 1'b1;
					res_d.data_len = 4'(PAYLOAD_BYTES);
					res_d.src      = SRC_TX;
				end
			end
			ACT_SPI_END: begin
				case (command)
					CMD_READ_BUF: begin
						if (!rx_empty) begin
							rx_pop           = 1'b1;
							res_d.resp_valid = 1'b1;
							res_d.data_len   = 4'(PAYLOAD_BYTES);
							res_d.src        = SRC_RX;
						end
					end
					CMD_WRITE_BUF: begin
						if (!tx_full) begin
							tx_push            = 1'b1;
							res_d.send_request = 1'b1;
						end
					end
					CMD_READ_REG: begin
						if (reg_sel inside {REG_RX_COUNT, REG_TX_COUNT, REG_OVERFLOW,
								REG_MAC_SETUP}) begin
							res_d.resp_valid = 1'b1;
							res_d.data_len   = 4'(WORD_BYTES);
							res_d.src        = SRC_WORD;
						end
						case (reg_sel)
							REG_RX_COUNT: res_d.word = 32'(rx_level_q);
							REG_TX_COUNT: res_d.word = 32'(tx_level_q);
							REG_OVERFLOW: begin
								res_d.word = overflow_q;
								ovf_clr    = 1'b1;
							end
							default: res_d.word = '0;
						endcase
					end
					CMD_WRITE_REG: begin
						if (reg_sel == REG_MAC_SETUP) begin
							q_clear                = 1'b1;
							res_d.mac_config_valid = 1'b1;
							res_d.station_id       = arg_m[15:8];
							res_d.station_count    = arg_m[23:16];
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	spb_ram #(.WIDTH(PKT_W), .DEPTH(RX_DEPTH), .AW(RX_AW)) u_rx_ram (
		.clk   (clk),
		.we    (accept && rx_push),
		.waddr (rx_waddr),
		.wdata (fill),
		.re    (accept && rx_pop),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	spb_ram #(.WIDTH(PKT_W), .DEPTH(TX_DEPTH), .AW(TX_AW)) u_tx_ram (
		.clk   (clk),
		.we    (accept && tx_push),
		.waddr (tx_waddr),
		.wdata (fill),
		.re    (accept && tx_pop),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	// queue pointers and lost-packet counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_level_q <= '0;
			tx_head_q  <= '0;
			tx_level_q <= '0;
			overflow_q <= '0;
		end else if (accept) begin
			if (q_clear) begin
				rx_head_q  <= '0;
				rx_level_q <= '0;
				tx_head_q  <= '0;
				tx_level_q <= '0;
			end
			if (rx_push) begin
				rx_level_q <= rx_level_q + 1'b1;
			end
			if (rx_pop) begin
				rx_level_q <= rx_level_q - 1'b1;
				rx_head_q  <= (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
			end
			if (tx_push) begin
				tx_level_q <= tx_level_q + 1'b1;
			end
			if (tx_pop) begin
				tx_level_q <= tx_level_q - 1'b1;
				tx_head_q  <= (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
			end
			if (ovf_inc) begin
				overflow_q <= overflow_q + 1'b1;
			end else if (ovf_clr) begin
				overflow_q <= '0;
			end
		end
	end

	// stage 1 waits for the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	always_comb begin
		case (res_s1.src)
			SRC_RX:   data_d = ARG_W'(rx_rdata);
			SRC_TX:   data_d = ARG_W'(tx_rdata);
			SRC_WORD: data_d = ARG_W'(res_s1.word);
			default:  data_d = '0;
		endcase
	end

	// output register: result beat holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q  <= res_s1;
			data_q <= data_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign resp_valid       = res_q.resp_valid;
	assign data_len         = res_q.data_len;
	assign data_low         = data_q[63:0];
	assign data_high        = data_q[95:64];
	assign ok               = res_q.ok;
	assign irq_pulse        = res_q.irq_pulse;
	assign send_request     = res_q.send_request;
	assign mac_config_valid = res_q.mac_config_valid;
	assign station_id       = res_q.station_id;
	assign station_count    = res_q.station_count;

	// ------------------------------------------------------------------------
	// assertions
	a_accept_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat did not enter stage 1");

	a_rx_level: assert property (@(posedge clk) disable iff (!arst_n)
		rx_level_q <= RX_LW'(RX_DEPTH))
		else $error("rx level beyond depth");

	a_tx_level: assert property (@(posedge clk) disable iff (!arst_n)
		tx_level_q <= TX_LW'(TX_DEPTH))
		else $error("tx level beyond depth");

	a_irq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_pulse) |-> (ok && !resp_valid && data_len == 4'd0))
		else $error("irq beat without clean radio accept");

endmodule
